### hw/rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared constants and control types for the spectral centroid and rolloff
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

    // Sample rate register and result widths.
    localparam int SR_W  = 18;
    localparam int OUT_W = 17;
    localparam int APB_W = 32;

    localparam logic [SR_W-1:0] SR_RESET = 18'd44100;

    // Rolloff threshold: cum * ROLL_DEN >= total * ROLL_NUM.
    localparam logic [6:0] ROLL_NUM = 7'd85;
    localparam logic [6:0] ROLL_DEN = 7'd100;

    // Register index of the sample rate register.
    localparam logic REG_SAMPLE_RATE = 1'b0;

    typedef struct packed {
        logic start;
    } t_cen_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cen_sts;

endpackage

`default_nettype wire

### hw/rtl/scr_bin_store.sv
// ----------------------------------------------------------------------------
// scr_bin_store
// Single-port-write, single-port-read memory holding one magnitude per bin,
// with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_bin_store #(
    parameter int FFT_SIZE = 4096,
    parameter int MAG_BITS = 24,
    localparam int DEPTH   = FFT_SIZE / 2,
    localparam int ADDR_W  = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire logic [MAG_BITS-1:0] i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output logic      [MAG_BITS-1:0] o_rd_data
);

    logic [MAG_BITS-1:0] r_mem [DEPTH];
    logic [MAG_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/scr_centroid.sv
// ----------------------------------------------------------------------------
// scr_centroid
// Iterative centroid unit: a restoring divide of the weighted sum by the
// total, a bit-serial fraction pass over the sample rate, and a final
// multiply-add and scale by the FFT size.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_centroid
    import scr_pkg::*;
#(
    parameter int FFT_SIZE = 4096,
    parameter int MAG_BITS = 24,
    localparam int DEPTH   = FFT_SIZE / 2,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int TOT_W   = MAG_BITS + CNT_W,
    localparam int WT_W    = MAG_BITS + 2 * CNT_W,
    localparam int LOG_FFT = $clog2(FFT_SIZE)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cen_ctl         i_ctl,
    input  wire logic [WT_W-1:0]  i_weighted,
    input  wire logic [TOT_W-1:0] i_total,
    input  wire logic [SR_W-1:0]  i_sample_rate,
    output t_cen_sts              o_sts,
    output logic      [OUT_W-1:0] o_centroid
);

    localparam int STEP_W = $clog2(WT_W);
    localparam int SC_W   = CNT_W + SR_W + 1;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_DIV  = 3'd1;
    localparam logic [2:0] C_FRAC = 3'd2;
    localparam logic [2:0] C_MUL  = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [TOT_W-1:0]  r_den;
    logic [WT_W-1:0]   r_num;
    logic [TOT_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_facc;
    logic [SR_W-1:0]   r_sr;
    logic [SR_W-1:0]   r_srate;
    logic [SR_W-1:0]   r_fq;
    logic [OUT_W-1:0]  r_result;

    // Restoring divide step.
    logic [TOT_W:0]    div_sh;
    logic [TOT_W:0]    div_diff;
    logic              div_ge;

    // Fraction step: floor(rem * sample_rate / total), one rate bit a cycle.
    logic [TOT_W+1:0]  fr_sum;
    logic [TOT_W+1:0]  fr_den1;
    logic [TOT_W+1:0]  fr_den2;
    logic [TOT_W+1:0]  fr_diff;
    logic              fr_ge1;
    logic              fr_ge2;
    logic [SR_W-1:0]   fr_q;

    logic [CNT_W+SR_W-1:0] mul_prod;
    logic [SC_W-1:0]       mul_sum;
    logic [SC_W-1:0]       mul_scaled;

    assign div_sh   = {r_rem, r_num[WT_W-1]};
    assign div_diff = div_sh - {1'b0, r_den};
    assign div_ge   = div_sh >= {1'b0, r_den};

    assign fr_den1 = {2'b00, r_den};
    assign fr_den2 = {1'b0, r_den, 1'b0};
    assign fr_sum  = {1'b0, r_facc, 1'b0} + (r_sr[SR_W-1] ? {2'b00, r_rem} : '0);
    assign fr_ge2  = fr_sum >= fr_den2;
    assign fr_ge1  = fr_sum >= fr_den1;
    assign fr_diff = fr_sum - (fr_ge2 ? fr_den2 : (fr_ge1 ? fr_den1 : '0));
    assign fr_q    = {r_fq[SR_W-2:0], 1'b0} + SR_W'({fr_ge2, fr_ge1 & ~fr_ge2});

    // The integer quotient never exceeds DEPTH, the largest bin weight.
    assign mul_prod   = r_num[CNT_W-1:0] * r_srate;
    assign mul_sum    = SC_W'(mul_prod) + SC_W'(r_fq);
    assign mul_scaled = mul_sum >> LOG_FFT;

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_total == '0) ? C_DONE : C_DIV;
                end
            end
            C_DIV: begin
                if (r_step == '0) begin
                    n_state = C_FRAC;
                end
            end
            C_FRAC: begin
                if (r_step == '0) begin
                    n_state = C_MUL;
                end
            end
            C_MUL:   n_state = C_DONE;
            C_DONE:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                C_IDLE: r_step <= STEP_W'(WT_W - 1);
                C_DIV:  r_step <= (r_step == '0) ? STEP_W'(SR_W - 1) : r_step - 1'b1;
                C_FRAC: r_step <= r_step - 1'b1;
                default: r_step <= r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_ctl.start) begin
                    r_den    <= i_total;
                    r_num    <= i_weighted;
                    r_rem    <= '0;
                    r_facc   <= '0;
                    r_fq     <= '0;
                    r_sr     <= i_sample_rate;
                    r_srate  <= i_sample_rate;
                    r_result <= '0;
                end
            end
            C_DIV: begin
                r_rem <= div_ge ? div_diff[TOT_W-1:0] : div_sh[TOT_W-1:0];
                r_num <= {r_num[WT_W-2:0], div_ge};
            end
            C_FRAC: begin
                r_facc <= fr_diff[TOT_W-1:0];
                r_fq   <= fr_q;
                r_sr   <= {r_sr[SR_W-2:0], 1'b0};
            end
            C_MUL: begin
                r_result <= mul_scaled[OUT_W-1:0];
            end
            default: begin
                r_result <= r_result;
            end
        endcase
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = (r_state == C_DONE);
    assign o_centroid = r_result;

endmodule

`default_nettype wire

### hw/rtl/spectral_centroid_rolloff.sv
// ----------------------------------------------------------------------------
// spectral_centroid_rolloff
// Loads one bin word per cycle into the bin store while accumulating the
// total and weighted sums. The last word starts a rolloff pass that reads the
// store once per cycle through the single read port, then the centroid unit
// runs (going straight to done when the total is zero) and the results are
// loaded into the output register. Input stalls from the last word until the
// result is in the output register. Reset clears control, sums and the output
// valid and sets the sample rate to 44100; store contents are left as is.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_centroid_rolloff
    import scr_pkg::*;
#(
    parameter int FFT_SIZE = 4096,
    parameter int MAG_BITS = 24,
    localparam int DEPTH   = FFT_SIZE / 2,
    localparam int ADDR_W  = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int TOT_W   = MAG_BITS + CNT_W,
    localparam int WT_W    = MAG_BITS + 2 * CNT_W,
    localparam int LOG_FFT = $clog2(FFT_SIZE)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [MAG_BITS-1:0] i_magnitude,
    input  wire logic                i_last,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic      [OUT_W-1:0]    o_centroid_hz,
    output logic      [OUT_W-1:0]    o_rolloff_hz,
    output logic                     o_overflow,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic      [APB_W-1:0]    prdata,
    output logic                     pready
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_ROLL = 2'd1;
    localparam logic [1:0] S_CEN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int CMP_W = TOT_W + 7;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [SR_W-1:0]     r_sample_rate;
    logic [CNT_W-1:0]    r_bin_count;
    logic [TOT_W-1:0]    r_total;
    logic [WT_W-1:0]     r_weighted;
    logic                r_dropped;

    logic [CNT_W-1:0]    r_rd_addr;
    logic                r_s1_vld;
    logic [CNT_W-1:0]    r_s1_idx;
    logic                r_s2_vld;
    logic [CNT_W-1:0]    r_s2_idx;
    logic [TOT_W-1:0]    r_cum;
    logic [CMP_W-1:0]    r_t85;
    logic [CNT_W-1:0]    r_k;
    logic [CNT_W+SR_W-1:0] r_roll_prod;
    logic                r_cen_start;

    logic                r_o_valid;
    logic [OUT_W-1:0]    r_o_centroid;
    logic [OUT_W-1:0]    r_o_rolloff;
    logic                r_o_overflow;

    logic                in_acc;
    logic                store_en;
    logic [CNT_W-1:0]    n_index;
    logic [MAG_BITS+CNT_W-1:0] wt_prod;
    logic                cfg_wr;
    logic                rd_en;
    logic [MAG_BITS-1:0] rd_data;
    logic [CMP_W-1:0]    cum_x100;
    logic                roll_hit;
    logic                roll_end;
    logic                go_cen;
    logic                out_load;
    logic [CNT_W+SR_W-1:0] roll_shift;
    t_cen_ctl            cen_ctl;
    t_cen_sts            cen_sts;
    logic [OUT_W-1:0]    cen_value;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_LOAD);
    assign store_en = in_acc && (r_bin_count < CNT_W'(DEPTH));
    assign n_index  = r_bin_count + 1'b1;
    assign wt_prod  = i_magnitude * n_index;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? APB_W'(r_sample_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
        end else if (cfg_wr && (paddr[2] == REG_SAMPLE_RATE)) begin
            r_sample_rate <= pwdata[SR_W-1:0];
        end
    end

    // Rolloff pass: read, accumulate, then compare against 85 percent.
    assign rd_en    = (r_state == S_ROLL) && (r_rd_addr < r_bin_count);
    assign cum_x100 = CMP_W'(r_cum) * CMP_W'(ROLL_DEN);
    assign roll_hit = r_s2_vld && (cum_x100 >= r_t85);
    assign roll_end = r_s2_vld && (r_s2_idx == r_bin_count - 1'b1);
    assign go_cen   = roll_hit || roll_end || (r_bin_count == '0);

    scr_bin_store #(
        .FFT_SIZE (FFT_SIZE),
        .MAG_BITS (MAG_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_en),
        .i_wr_addr (r_bin_count[ADDR_W-1:0]),
        .i_wr_data (i_magnitude),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign cen_ctl.start = r_cen_start;

    scr_centroid #(
        .FFT_SIZE (FFT_SIZE),
        .MAG_BITS (MAG_BITS)
    ) u_centroid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (cen_ctl),
        .i_weighted    (r_weighted),
        .i_total       (r_total),
        .i_sample_rate (r_sample_rate),
        .o_sts         (cen_sts),
        .o_centroid    (cen_value)
    );

    assign out_load   = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign roll_shift = r_roll_prod >> LOG_FFT;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_last) begin
                    n_state = S_ROLL;
                end
            end
            S_ROLL: begin
                if (go_cen) begin
                    n_state = S_CEN;
                end
            end
            S_CEN: begin
                if (cen_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_bin_count <= '0;
            r_total     <= '0;
            r_weighted  <= '0;
            r_dropped   <= 1'b0;
            r_rd_addr   <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_cum       <= '0;
            r_k         <= '0;
            r_cen_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cen_start <= (r_state == S_ROLL) && go_cen;

            if (store_en) begin
                r_bin_count <= n_index;
                r_total     <= r_total + TOT_W'(i_magnitude);
                r_weighted  <= r_weighted + WT_W'(wt_prod);
            end else if (in_acc) begin
                r_dropped <= 1'b1;
            end

            if (in_acc && i_last) begin
                r_rd_addr <= '0;
                r_s1_vld  <= 1'b0;
                r_s2_vld  <= 1'b0;
                r_cum     <= '0;
                r_k       <= '0;
            end

            if (r_state == S_ROLL) begin
                if (rd_en) begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
                r_s1_vld <= rd_en;
                r_s2_vld <= r_s1_vld && !roll_hit;
                if (r_s1_vld) begin
                    r_cum <= r_cum + TOT_W'(rd_data);
                end
                if (roll_hit) begin
                    r_k <= r_s2_idx + 1'b1;
                end
            end

            // The sums are cleared once the result has been captured.
            if (out_load) begin
                r_bin_count <= '0;
                r_total     <= '0;
                r_weighted  <= '0;
                r_dropped   <= 1'b0;
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROLL) begin
            r_s1_idx <= r_rd_addr;
            r_s2_idx <= r_s1_idx;
            r_t85    <= CMP_W'(r_total) * CMP_W'(ROLL_NUM);
        end
        r_roll_prod <= r_k * r_sample_rate;
        if (out_load) begin
            r_o_centroid <= cen_value;
            r_o_rolloff  <= roll_shift[OUT_W-1:0];
            r_o_overflow <= r_dropped;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_centroid_hz = r_o_centroid;
    assign o_rolloff_hz  = r_o_rolloff;
    assign o_overflow    = r_o_overflow;

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> o_stall)
        else $error("input not stalled after the last bin word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_count <= CNT_W'(DEPTH))
        else $error("bin count beyond store depth");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cen_start |-> !cen_sts.busy)
        else $error("centroid unit started while busy");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_k <= r_bin_count))
        else $error("rolloff bin beyond loaded bins");

endmodule

`default_nettype wire
